[rtl/gpc_pkg.sv]
// shared types and constants for the gamepad poll conditioner
package gpc_pkg;

   localparam int PadSlots = 4;

   localparam logic [7:0]  ClickThresholdReset = 8'd200;
   localparam logic [14:0] StickDeadzoneReset  = 15'd7849;
   localparam logic [15:0] HoldLimitReset      = 16'd500;

   localparam logic [15:0] FullPos   = 16'h7FFF;
   localparam logic [15:0] FullScale = 16'h8000;
   localparam logic [15:0] HeldMax   = 16'hFFFF;

   localparam logic [1:0] CsrClickThreshold = 2'd0;
   localparam logic [1:0] CsrStickDeadzone  = 2'd1;
   localparam logic [1:0] CsrHoldLimit      = 2'd2;

   typedef enum logic [1:0] {
      StIdle,
      StSetup,
      StDivide,
      StDone
   } state_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_stat_type;

   typedef struct packed {
      logic [7:0]        trigger_level;
      logic              trigger_click;
      logic              pad_present;
      logic [3:0]        connected_mask;
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic              stick_click;
      logic              system_pressed;
      logic              tap_pulse;
      logic              hold_pulse;
   } result_type;

endpackage

[rtl/gpc_if.sv]
// channel interfaces for pad reports, poll results and register writes

interface gpc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        slot;
   logic              connected;
   logic [7:0]        left_trigger;
   logic [7:0]        right_trigger;
   logic              system_button;
   logic              thumb_click;
   logic signed [15:0] thumb_x;
   logic signed [15:0] thumb_y;
   logic [7:0]        elapsed_ms;
   logic              last_slot;

   modport source (output valid, slot, connected, left_trigger, right_trigger,
                   system_button, thumb_click, thumb_x, thumb_y, elapsed_ms,
                   last_slot, input ready);
   modport sink (input valid, slot, connected, left_trigger, right_trigger,
                 system_button, thumb_click, thumb_x, thumb_y, elapsed_ms,
                 last_slot, output ready);
endinterface

interface gpc_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        trigger_level;
   logic              trigger_click;
   logic              pad_present;
   logic [3:0]        connected_mask;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   logic              stick_click;
   logic              system_pressed;
   logic              tap_pulse;
   logic              hold_pulse;

   modport source (output valid, trigger_level, trigger_click, pad_present,
                   connected_mask, stick_x, stick_y, stick_click, system_pressed,
                   tap_pulse, hold_pulse, input ready);
   modport sink (input valid, trigger_level, trigger_click, pad_present,
                 connected_mask, stick_x, stick_y, stick_click, system_pressed,
                 tap_pulse, hold_pulse, output ready);
endinterface

interface gpc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/gpc_divider.sv]
// radix-2 restoring divider, one quotient bit per cycle, quotient known to fit 16 bits
module gpc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gpc_pkg::div_cmd_type cmd,
   output gpc_pkg::div_stat_type stat
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] shift_ff, shift_in;
   logic [15:0] den_ff, den_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] part;
   logic [16:0] diff;

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      part     = {rem_ff, shift_ff[15]};
      diff     = part - {1'b0, den_ff};
      if (cmd.start) begin
         // dividend is scaled by 2^15: top bits seed the remainder
         rem_in   = {1'b0, cmd.dividend[15:1]};
         shift_in = {cmd.dividend[0], 15'd0};
         den_in   = cmd.divisor;
         cnt_in   = 4'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in   = diff[15:0];
            shift_in = {shift_ff[14:0], 1'b1};
         end else begin
            rem_in   = part[15:0];
            shift_in = {shift_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      den_ff   <= den_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = shift_ff;

endmodule

[rtl/gamepad_poll_conditioner.sv]
// top level: poll accumulation, tap/hold machine and stick scaling sequencer
//
// Pad-slot reports are taken one per transfer; a report without the last-slot
// flag is absorbed without leaving the idle state and produces no result. A
// report with the last-slot flag closes the poll; no further report is taken
// until its result is in the output register. Each stick axis outside the
// deadzone is scaled, one after the other, through a single shared divider
// that yields one quotient bit per cycle. The finished result sits in an output
// register, so the next poll may start while it waits to be taken. Register
// writes are accepted at any cycle and must be issued while the block is idle.
module gamepad_poll_conditioner (
   input  logic       clock,
   input  logic       reset,
   gpc_req_if.sink    req_if,
   gpc_rsp_if.source  rsp_if,
   gpc_csr_if.sink    csr_if
);

   gpc_pkg::state_type    state_ff, state_in;
   gpc_pkg::div_cmd_type  div_cmd;
   gpc_pkg::div_stat_type div_stat;

   logic [7:0]  click_thr_ff, click_thr_in;
   logic [14:0] deadzone_ff, deadzone_in;
   logic [15:0] hold_limit_ff, hold_limit_in;

   logic [7:0]  best_trig_ff, best_trig_in;
   logic [3:0]  slot_mask_ff, slot_mask_in;
   logic        any_sys_ff, any_sys_in;
   logic        prim_taken_ff, prim_taken_in;
   logic [15:0] prim_x_ff, prim_x_in;
   logic [15:0] prim_y_ff, prim_y_in;
   logic        prim_click_ff, prim_click_in;

   logic        btn_held_ff, btn_held_in;
   logic        hold_fired_ff, hold_fired_in;
   logic [15:0] held_time_ff, held_time_in;

   gpc_pkg::result_type work_ff, work_in;
   gpc_pkg::result_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] axis_x_ff, axis_x_in;
   logic [15:0] axis_y_ff, axis_y_in;
   logic        axis_sel_ff, axis_sel_in;
   logic        axis_neg_ff, axis_neg_in;

   logic        req_fire;
   logic        take;
   logic [7:0]  acc_trig;
   logic [3:0]  acc_mask;
   logic        acc_sys;
   logic [16:0] held_sum;
   logic [15:0] raw_axis;
   logic signed [16:0] v_ext;
   logic signed [16:0] d_ext;
   logic signed [16:0] v_minus_d;
   logic signed [16:0] v_plus_d;
   logic [15:0] q;
   logic [15:0] axis_val;

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == gpc_pkg::StIdle);
   assign csr_if.ready = 1'b1;

   always_comb begin
      click_thr_in  = click_thr_ff;
      deadzone_in   = deadzone_ff;
      hold_limit_in = hold_limit_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            gpc_pkg::CsrClickThreshold: click_thr_in  = csr_if.data[7:0];
            gpc_pkg::CsrStickDeadzone:  deadzone_in   = csr_if.data[14:0];
            gpc_pkg::CsrHoldLimit:      hold_limit_in = csr_if.data;
            default: ;
         endcase
      end
   end

   gpc_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   always_comb begin
      state_in      = state_ff;
      best_trig_in  = best_trig_ff;
      slot_mask_in  = slot_mask_ff;
      any_sys_in    = any_sys_ff;
      prim_taken_in = prim_taken_ff;
      prim_x_in     = prim_x_ff;
      prim_y_in     = prim_y_ff;
      prim_click_in = prim_click_ff;
      btn_held_in   = btn_held_ff;
      hold_fired_in = hold_fired_ff;
      held_time_in  = held_time_ff;
      work_in       = work_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      axis_x_in     = axis_x_ff;
      axis_y_in     = axis_y_ff;
      axis_sel_in   = axis_sel_ff;
      axis_neg_in   = axis_neg_ff;
      div_cmd       = '0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // report accumulation
      take     = req_if.connected && (32'(req_if.slot) < gpc_pkg::PadSlots);
      acc_trig = best_trig_ff;
      acc_mask = slot_mask_ff;
      acc_sys  = any_sys_ff;
      if (take) begin
         acc_mask = slot_mask_ff | (4'b0001 << req_if.slot);
         if (req_if.left_trigger > acc_trig) begin
            acc_trig = req_if.left_trigger;
         end
         if (req_if.right_trigger > acc_trig) begin
            acc_trig = req_if.right_trigger;
         end
         acc_sys = any_sys_ff | req_if.system_button;
      end
      held_sum = {1'b0, held_time_ff} + {9'd0, req_if.elapsed_ms};

      // axis selection and deadzone branch
      raw_axis  = axis_sel_ff ? axis_y_ff : axis_x_ff;
      v_ext     = {raw_axis[15], raw_axis};
      d_ext     = {2'b00, deadzone_ff};
      v_minus_d = v_ext - d_ext;
      v_plus_d  = v_ext + d_ext;

      q        = div_stat.quotient;
      axis_val = axis_neg_ff ? (~q + 16'd1) : ((q > gpc_pkg::FullPos) ? gpc_pkg::FullPos : q);

      unique case (state_ff)
         gpc_pkg::StIdle: begin
            if (req_fire) begin
               best_trig_in = acc_trig;
               slot_mask_in = acc_mask;
               any_sys_in   = acc_sys;
               if (take && !prim_taken_ff) begin
                  prim_taken_in = 1'b1;
                  prim_x_in     = req_if.thumb_x;
                  prim_y_in     = req_if.thumb_y;
                  prim_click_in = req_if.thumb_click;
               end
               if (req_if.last_slot) begin
                  work_in.trigger_level  = acc_trig;
                  work_in.trigger_click  = (acc_trig >= click_thr_ff);
                  work_in.pad_present    = (acc_mask != 4'd0);
                  work_in.connected_mask = acc_mask;
                  work_in.system_pressed = acc_sys;
                  work_in.stick_click    = prim_taken_ff ? prim_click_ff
                                           : (take && req_if.thumb_click);
                  work_in.tap_pulse      = 1'b0;
                  work_in.hold_pulse     = 1'b0;
                  work_in.stick_x        = '0;
                  work_in.stick_y        = '0;
                  axis_x_in = prim_taken_ff ? prim_x_ff
                              : (take ? req_if.thumb_x : 16'd0);
                  axis_y_in = prim_taken_ff ? prim_y_ff
                              : (take ? req_if.thumb_y : 16'd0);
                  axis_sel_in = 1'b0;
                  priority if (acc_sys && !btn_held_ff) begin
                     btn_held_in   = 1'b1;
                     held_time_in  = 16'd0;
                     hold_fired_in = 1'b0;
                  end else if (acc_sys && !hold_fired_ff) begin
                     held_time_in = held_sum[16] ? gpc_pkg::HeldMax : held_sum[15:0];
                     if ((held_sum[16] ? gpc_pkg::HeldMax : held_sum[15:0])
                         >= hold_limit_ff) begin
                        work_in.hold_pulse = 1'b1;
                        hold_fired_in      = 1'b1;
                     end
                  end else if (!acc_sys && btn_held_ff) begin
                     work_in.tap_pulse = !hold_fired_ff;
                     btn_held_in       = 1'b0;
                  end else begin
                  end
                  best_trig_in  = '0;
                  slot_mask_in  = '0;
                  any_sys_in    = 1'b0;
                  prim_taken_in = 1'b0;
                  prim_x_in     = '0;
                  prim_y_in     = '0;
                  prim_click_in = 1'b0;
                  state_in      = gpc_pkg::StSetup;
               end
            end
         end
         gpc_pkg::StSetup: begin
            priority if (v_minus_d > 17'sd0) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = v_minus_d[15:0];
               div_cmd.divisor  = gpc_pkg::FullPos - {1'b0, deadzone_ff};
               axis_neg_in      = 1'b0;
               state_in         = gpc_pkg::StDivide;
            end else if (v_plus_d < 17'sd0) begin
               div_cmd.start    = 1'b1;
               div_cmd.dividend = 16'(-v_plus_d);
               div_cmd.divisor  = gpc_pkg::FullScale - {1'b0, deadzone_ff};
               axis_neg_in      = 1'b1;
               state_in         = gpc_pkg::StDivide;
            end else begin
               // inside the deadzone: axis stays zero
               if (axis_sel_ff) begin
                  state_in = gpc_pkg::StDone;
               end else begin
                  axis_sel_in = 1'b1;
               end
            end
         end
         gpc_pkg::StDivide: begin
            if (div_stat.done) begin
               if (axis_sel_ff) begin
                  work_in.stick_y = axis_val;
                  state_in        = gpc_pkg::StDone;
               end else begin
                  work_in.stick_x = axis_val;
                  axis_sel_in     = 1'b1;
                  state_in        = gpc_pkg::StSetup;
               end
            end
         end
         gpc_pkg::StDone: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_in       = work_ff;
               rsp_valid_in = 1'b1;
               state_in     = gpc_pkg::StIdle;
            end
         end
         default: state_in = gpc_pkg::StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gpc_pkg::StIdle;
         click_thr_ff  <= gpc_pkg::ClickThresholdReset;
         deadzone_ff   <= gpc_pkg::StickDeadzoneReset;
         hold_limit_ff <= gpc_pkg::HoldLimitReset;
         best_trig_ff  <= '0;
         slot_mask_ff  <= '0;
         any_sys_ff    <= 1'b0;
         prim_taken_ff <= 1'b0;
         prim_x_ff     <= '0;
         prim_y_ff     <= '0;
         prim_click_ff <= 1'b0;
         btn_held_ff   <= 1'b0;
         hold_fired_ff <= 1'b0;
         held_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         axis_sel_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         click_thr_ff  <= click_thr_in;
         deadzone_ff   <= deadzone_in;
         hold_limit_ff <= hold_limit_in;
         best_trig_ff  <= best_trig_in;
         slot_mask_ff  <= slot_mask_in;
         any_sys_ff    <= any_sys_in;
         prim_taken_ff <= prim_taken_in;
         prim_x_ff     <= prim_x_in;
         prim_y_ff     <= prim_y_in;
         prim_click_ff <= prim_click_in;
         btn_held_ff   <= btn_held_in;
         hold_fired_ff <= hold_fired_in;
         held_time_ff  <= held_time_in;
         rsp_valid_ff  <= rsp_valid_in;
         axis_sel_ff   <= axis_sel_in;
      end
      work_ff     <= work_in;
      rsp_ff      <= rsp_in;
      axis_x_ff   <= axis_x_in;
      axis_y_ff   <= axis_y_in;
      axis_neg_ff <= axis_neg_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.trigger_level  = rsp_ff.trigger_level;
   assign rsp_if.trigger_click  = rsp_ff.trigger_click;
   assign rsp_if.pad_present    = rsp_ff.pad_present;
   assign rsp_if.connected_mask = rsp_ff.connected_mask;
   assign rsp_if.stick_x        = rsp_ff.stick_x;
   assign rsp_if.stick_y        = rsp_ff.stick_y;
   assign rsp_if.stick_click    = rsp_ff.stick_click;
   assign rsp_if.system_pressed = rsp_ff.system_pressed;
   assign rsp_if.tap_pulse      = rsp_ff.tap_pulse;
   assign rsp_if.hold_pulse     = rsp_ff.hold_pulse;

endmodule

[bench/gamepad_poll_conditioner_test.sv]
`timescale 1ns / 1ps
// self-checking bench for the gamepad poll conditioner: directed and random polls
module gamepad_poll_conditioner_test;

   localparam int CycleLimit  = 600000;
   localparam int DrainCycles = 60;
   localparam int HoldOffLen  = 400;

   typedef struct packed {
      logic [1:0]         slot;
      logic               connected;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
      logic               system_button;
      logic               thumb_click;
      logic signed [15:0] thumb_x;
      logic signed [15:0] thumb_y;
      logic [7:0]         elapsed_ms;
      logic               last_slot;
   } pad_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpc_req_if req_bus ();
   gpc_rsp_if rsp_bus ();
   gpc_csr_if csr_bus ();

   gamepad_poll_conditioner dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // register mirror
   logic [7:0]  click_level;
   logic [14:0] dead_band;
   logic [15:0] hold_limit;

   // poll accumulators and tap/hold state
   logic [7:0]         acc_trigger;
   logic [3:0]         acc_mask;
   logic               acc_system;
   logic               acc_primary;
   logic signed [15:0] acc_x;
   logic signed [15:0] acc_y;
   logic               acc_click;
   logic               btn_held;
   logic               btn_fired;
   int                 btn_time;

   pad_report_type      pending_reports[$];
   gpc_pkg::result_type expected_polls[$];
   pad_report_type      on_bus;

   int   mismatches = 0;
   int   cycle_count = 0;
   int   send_gap = 0;
   int   take_gap = 0;
   logic idling_on = 1'b0;
   logic pressure_on = 1'b0;
   logic rsp_hold_off = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [15:0] scale_stick(logic signed [15:0] raw,
                                                      logic [14:0] band);
      int v;
      int d;
      int q;
      v = raw;
      d = band;
      if (v > d) begin
         q = ((v - d) * int'(gpc_pkg::FullScale)) / (int'(gpc_pkg::FullPos) - d);
         if (q > int'(gpc_pkg::FullPos)) q = int'(gpc_pkg::FullPos);
         return 16'(q);
      end else if (v < -d) begin
         q = (-(v + d) * int'(gpc_pkg::FullScale)) / (int'(gpc_pkg::FullScale) - d);
         if (q > int'(gpc_pkg::FullScale)) q = int'(gpc_pkg::FullScale);
         return 16'(-q);
      end
      return '0;
   endfunction

   function automatic void absorb_report(pad_report_type r);
      gpc_pkg::result_type res;
      logic tap;
      logic hold;
      if (r.connected && r.slot < gpc_pkg::PadSlots) begin
         acc_mask[r.slot] = 1'b1;
         if (r.left_trigger > acc_trigger) acc_trigger = r.left_trigger;
         if (r.right_trigger > acc_trigger) acc_trigger = r.right_trigger;
         if (r.system_button) acc_system = 1'b1;
         if (!acc_primary) begin
            acc_primary = 1'b1;
            acc_x = r.thumb_x;
            acc_y = r.thumb_y;
            acc_click = r.thumb_click;
         end
      end
      if (!r.last_slot) return;
      tap = 1'b0;
      hold = 1'b0;
      if (acc_system && !btn_held) begin
         btn_held = 1'b1;
         btn_time = 0;
         btn_fired = 1'b0;
      end else if (acc_system && btn_held && !btn_fired) begin
         btn_time = btn_time + int'(r.elapsed_ms);
         if (btn_time > int'(gpc_pkg::HeldMax)) btn_time = int'(gpc_pkg::HeldMax);
         if (btn_time >= int'(hold_limit)) begin
            hold = 1'b1;
            btn_fired = 1'b1;
         end
      end else if (!acc_system && btn_held) begin
         tap = !btn_fired;
         btn_held = 1'b0;
      end
      res.trigger_level  = acc_trigger;
      res.trigger_click  = (acc_trigger >= click_level);
      res.pad_present    = (acc_mask != 4'd0);
      res.connected_mask = acc_mask;
      res.stick_x        = scale_stick(acc_x, dead_band);
      res.stick_y        = scale_stick(acc_y, dead_band);
      res.stick_click    = acc_click;
      res.system_pressed = acc_system;
      res.tap_pulse      = tap;
      res.hold_pulse     = hold;
      expected_polls.push_back(res);
      acc_trigger = '0;
      acc_mask    = '0;
      acc_system  = 1'b0;
      acc_primary = 1'b0;
      acc_x       = '0;
      acc_y       = '0;
      acc_click   = 1'b0;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // report driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) absorb_report(on_bus);
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered report
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_reports.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 2);
            req_bus.valid <= 1'b0;
         end else begin
            on_bus = pending_reports.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.slot          <= on_bus.slot;
            req_bus.connected     <= on_bus.connected;
            req_bus.left_trigger  <= on_bus.left_trigger;
            req_bus.right_trigger <= on_bus.right_trigger;
            req_bus.system_button <= on_bus.system_button;
            req_bus.thumb_click   <= on_bus.thumb_click;
            req_bus.thumb_x       <= on_bus.thumb_x;
            req_bus.thumb_y       <= on_bus.thumb_y;
            req_bus.elapsed_ms    <= on_bus.elapsed_ms;
            req_bus.last_slot     <= on_bus.last_slot;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : result_monitor
      gpc_pkg::result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_polls.size() == 0) begin
               $error("result transfer with no poll outstanding");
               mismatches++;
            end else begin
               want = expected_polls.pop_front();
               check_field("trigger_level", want.trigger_level, rsp_bus.trigger_level);
               check_field("trigger_click", want.trigger_click, rsp_bus.trigger_click);
               check_field("pad_present", want.pad_present, rsp_bus.pad_present);
               check_field("connected_mask", want.connected_mask, rsp_bus.connected_mask);
               check_field("stick_x", want.stick_x, rsp_bus.stick_x);
               check_field("stick_y", want.stick_y, rsp_bus.stick_y);
               check_field("stick_click", want.stick_click, rsp_bus.stick_click);
               check_field("system_pressed", want.system_pressed, rsp_bus.system_pressed);
               check_field("tap_pulse", want.tap_pulse, rsp_bus.tap_pulse);
               check_field("hold_pulse", want.hold_pulse, rsp_bus.hold_pulse);
            end
         end
         if (rsp_hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            take_gap = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver stall so the block backs up into the report channel
   initial begin : receiver_hold_off
      wait (pressure_on);
      @(posedge clock);
      rsp_hold_off <= 1'b1;
      repeat (HoldOffLen) @(posedge clock);
      rsp_hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("gamepad_poll_conditioner_test: errors");
         $finish;
      end
   end

   function automatic pad_report_type pad_report(logic [1:0] slot, logic conn,
                                                 logic [7:0] lt, logic [7:0] rt,
                                                 logic sys, logic clk,
                                                 logic signed [15:0] x,
                                                 logic signed [15:0] y,
                                                 logic [7:0] ms, logic last);
      pad_report_type r;
      r.slot = slot;
      r.connected = conn;
      r.left_trigger = lt;
      r.right_trigger = rt;
      r.system_button = sys;
      r.thumb_click = clk;
      r.thumb_x = x;
      r.thumb_y = y;
      r.elapsed_ms = ms;
      r.last_slot = last;
      return r;
   endfunction

   function automatic logic [7:0] pick_trigger();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return click_level;
         3: return click_level - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] pick_axis();
      int b;
      b = dead_band;
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'(b);
         3: return 16'(-b);
         4: return 16'(b + 1);
         5: return 16'(-b - 1);
         6: return 16'(int'($urandom_range(0, 400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pad_report_type random_report(logic [1:0] slot, logic last, logic press);
      pad_report_type r;
      r.slot = slot;
      r.connected = ($urandom_range(0, 3) != 0);
      r.left_trigger = pick_trigger();
      r.right_trigger = pick_trigger();
      r.system_button = ($urandom_range(0, 9) == 0) ? !press : press;
      r.thumb_click = 1'($urandom);
      r.thumb_x = pick_axis();
      r.thumb_y = pick_axis();
      r.elapsed_ms = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
      r.last_slot = last;
      return r;
   endfunction

   // mostly well-formed polls with a sticky system button, some loose reports
   function automatic void queue_polls(int n_items);
      pad_report_type r;
      int added;
      int count;
      int k;
      logic [1:0] s;
      logic press;
      added = 0;
      press = 1'b0;
      while (added < n_items) begin
         if ($urandom_range(0, 3) == 0) press = !press;
         if ($urandom_range(0, 9) == 0) begin
            r = random_report(2'($urandom), 1'($urandom), press);
            pending_reports.push_back(r);
            added++;
         end else begin
            count = $urandom_range(1, 4);
            for (k = 0; k < count; k++) begin
               s = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'(k);
               r = random_report(s, k == count - 1, press);
               pending_reports.push_back(r);
               added++;
            end
         end
      end
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         gpc_pkg::CsrClickThreshold: click_level = value[7:0];
         gpc_pkg::CsrStickDeadzone:  dead_band = value[14:0];
         gpc_pkg::CsrHoldLimit:      hold_limit = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [7:0] thr, logic [14:0] band, logic [15:0] limit);
      write_csr(gpc_pkg::CsrClickThreshold, 16'(thr));
      write_csr(gpc_pkg::CsrStickDeadzone, 16'(band));
      write_csr(gpc_pkg::CsrHoldLimit, limit);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_reports.size() != 0 || req_bus.valid || expected_polls.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin : stimulus
      int k;
      req_bus.valid = 1'b0;
      req_bus.slot = '0;
      req_bus.connected = 1'b0;
      req_bus.left_trigger = '0;
      req_bus.right_trigger = '0;
      req_bus.system_button = 1'b0;
      req_bus.thumb_click = 1'b0;
      req_bus.thumb_x = '0;
      req_bus.thumb_y = '0;
      req_bus.elapsed_ms = '0;
      req_bus.last_slot = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      click_level = gpc_pkg::ClickThresholdReset;
      dead_band = gpc_pkg::StickDeadzoneReset;
      hold_limit = gpc_pkg::HoldLimitReset;
      acc_trigger = '0;
      acc_mask = '0;
      acc_system = 1'b0;
      acc_primary = 1'b0;
      acc_x = '0;
      acc_y = '0;
      acc_click = 1'b0;
      btn_held = 1'b0;
      btn_fired = 1'b0;
      btn_time = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      // empty poll, extremes, repeated slot, first slot absent, tap, hold
      pending_reports.push_back(pad_report(0, 0, 8'd255, 8'd255, 1, 1, 16'sd5, 16'sd5, 0, 1));
      pending_reports.push_back(pad_report(0, 1, 8'd255, 8'd0, 0, 1, 16'sh7FFF, 16'sh8000,
                                           0, 1));
      pending_reports.push_back(pad_report(1, 1, 8'd0, 8'd255, 0, 0, -16'sd32767, 16'sd7849,
                                           0, 0));
      pending_reports.push_back(pad_report(2, 1, 8'd199, 8'd200, 0, 1, 16'sd7850, -16'sd7849,
                                           0, 0));
      pending_reports.push_back(pad_report(1, 1, 8'd0, 8'd0, 0, 0, 16'sd1, 16'sd1, 0, 1));
      pending_reports.push_back(pad_report(0, 0, 8'd255, 8'd0, 1, 1, 16'sd9000, 16'sd0, 0, 0));
      pending_reports.push_back(pad_report(3, 1, 8'd200, 8'd0, 0, 0, -16'sd7850, 16'sd0,
                                           0, 1));
      pending_reports.push_back(pad_report(1, 0, 8'd0, 8'd0, 1, 0, 16'sd0, 16'sd0, 0, 0));
      pending_reports.push_back(pad_report(0, 1, 8'd10, 8'd20, 1, 0, 16'sd0, 16'sd0, 100, 1));
      pending_reports.push_back(pad_report(0, 1, 8'd10, 8'd20, 0, 0, 16'sd0, 16'sd0, 100, 1));
      for (k = 0; k < 4; k++)
         pending_reports.push_back(pad_report(2, 1, 8'd1, 8'd2, 1, 0, 16'sd0, 16'sd0,
                                              8'd255, 1));
      pending_reports.push_back(pad_report(2, 1, 8'd1, 8'd2, 0, 0, 16'sd0, 16'sd0, 8'd255, 1));
      queue_polls(250);
      wait_idle();

      // zero threshold, no deadzone, zero hold limit
      set_config(8'd0, 15'd0, 16'd0);
      pending_reports.push_back(pad_report(3, 0, 8'd0, 8'd0, 0, 0, 16'sd0, 16'sd0, 0, 1));
      pending_reports.push_back(pad_report(0, 1, 8'd0, 8'd0, 0, 0, 16'sd1, -16'sd1, 0, 1));
      pending_reports.push_back(pad_report(0, 1, 8'd0, 8'd0, 1, 0, 16'sd0, 16'sd0, 0, 1));
      pending_reports.push_back(pad_report(0, 1, 8'd0, 8'd0, 1, 0, 16'sd0, 16'sd0, 0, 1));
      pending_reports.push_back(pad_report(0, 1, 8'd0, 8'd0, 0, 0, 16'sd0, 16'sd0, 0, 1));
      queue_polls(200);
      wait_idle();

      // largest settings; a press long enough to saturate the hold timer
      set_config(8'd255, 15'd32766, 16'hFFFF);
      idling_on = 1'b0;
      for (k = 0; k < 265; k++)
         pending_reports.push_back(pad_report(1, 1, 8'($urandom), 8'($urandom), 1, 1'($urandom),
                                              16'($urandom), 16'($urandom), 8'd250, 1));
      pending_reports.push_back(pad_report(1, 1, 8'd255, 8'd255, 0, 0, 16'sh7FFF, 16'sh8000,
                                           8'd250, 1));
      wait_idle();
      idling_on = 1'b1;
      queue_polls(120);
      wait_idle();

      set_config(8'($urandom), 15'($urandom_range(0, 32766)), 16'($urandom_range(0, 1000)));
      pressure_on = 1'b1;
      queue_polls(300);
      wait_idle();

      set_config(8'($urandom), 15'($urandom_range(0, 32766)), 16'($urandom_range(0, 1000)));
      queue_polls(250);
      wait_idle();

      idling_on = 1'b0;
      set_config(8'($urandom), 15'($urandom_range(0, 32766)), 16'($urandom_range(0, 1000)));
      queue_polls(200);
      wait_idle();

      if (mismatches == 0) begin
         $display("gamepad_poll_conditioner_test: clean");
      end else begin
         $display("gamepad_poll_conditioner_test: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/gpc_pkg.sv
rtl/gpc_if.sv
rtl/gpc_divider.sv
rtl/gamepad_poll_conditioner.sv
bench/gamepad_poll_conditioner_test.sv
